// File: rtl/sbfm_pkg.sv
// ----------------------------------------------------------------------------
// sbfm_pkg
// shared types, constants and table functions of the sloped block face mesher
// ----------------------------------------------------------------------------
package sbfm_pkg;

  // face word layout
  localparam int unsigned TexW     = 10;
  localparam int unsigned FlipBit  = 13;
  localparam int unsigned RotLsb   = 14;
  localparam int unsigned NumFaces = 5;

  // slope type ranges
  localparam logic [5:0] TYPE_TWO_LO   = 6'd1;
  localparam logic [5:0] TYPE_TWO_HI   = 6'd8;
  localparam logic [5:0] TYPE_EIGHT_LO = 6'd9;
  localparam logic [5:0] TYPE_EIGHT_HI = 6'd40;
  localparam logic [5:0] TYPE_ONE_LO   = 6'd41;
  localparam logic [5:0] TYPE_ONE_HI   = 6'd44;

  // last vertex of a face
  localparam logic [2:0] VTX_LAST = 3'd5;

  // base height in eighths
  localparam logic [3:0] Z_FLOOR = 4'b1000;

  typedef enum logic [2:0] {
    FACE_LID    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_LEFT   = 3'd3,
    FACE_RIGHT  = 3'd4
  } face_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [TexW-1:0] tex;
    logic            flip;
    logic [1:0]      rot;
  } face_t;

  // one classified block as it sits in the queue
  typedef struct packed {
    logic [3:0][3:0]          lid_z;   // signed eighths per lid corner
    face_t [NumFaces-1:0]     face;
    logic [NumFaces-1:0]      mask;    // faces with a nonzero texture
    logic [3:0]               ox;
    logic [4:0]               oy;      // signed
    logic [3:0]               oz;
  } entry_t;

  // quad corner used by each vertex of the two triangles
  function automatic logic [1:0] tri_corner(input logic [2:0] vtx);
    logic [1:0] q;
    case (vtx)
      3'd0:    q = 2'd0;
      3'd1:    q = 2'd1;
      3'd2:    q = 2'd2;
      3'd3:    q = 2'd0;
      3'd4:    q = 2'd2;
      default: q = 2'd3;
    endcase
    return q;
  endfunction

  // quad point of a face: bit 2 set means a base corner, bits 1:0 the corner
  function automatic logic [2:0] face_point(input logic [2:0] f, input logic [1:0] q);
    logic [11:0] row;
    case (f)
      FACE_LID:    row = {3'd3, 3'd2, 3'd1, 3'd0};
      FACE_BOTTOM: row = {3'd0, 3'd1, 3'd5, 3'd4};
      FACE_TOP:    row = {3'd3, 3'd2, 3'd6, 3'd7};
      FACE_LEFT:   row = {3'd0, 3'd3, 3'd7, 3'd4};
      default:     row = {3'd2, 3'd1, 3'd5, 3'd6};
    endcase
    return row[3*q +: 3];
  endfunction

  function automatic logic sq_x(input logic [1:0] c);
    return c[0] ^ c[1];
  endfunction

  function automatic logic sq_y(input logic [1:0] c);
    return c[1];
  endfunction

  // lowest pending face
  function automatic logic [2:0] first_face(input logic [NumFaces-1:0] pend);
    logic [2:0] f;
    f = 3'd0;
    for (int i = NumFaces - 1; i >= 0; i--) begin
      if (pend[i]) begin
        f = 3'(i);
      end
    end
    return f;
  endfunction

endpackage

// File: rtl/sbfm_front.sv
// ----------------------------------------------------------------------------
// sbfm_front
// takes a block in, works out its lid heights and textured faces
// ----------------------------------------------------------------------------
module sbfm_front import sbfm_pkg::*; (
  input  logic        start_i,
  input  logic        full_i,
  input  logic [7:0]  slope_code_i,
  input  logic [15:0] lid_word_i,
  input  logic [15:0] bottom_word_i,
  input  logic [15:0] top_word_i,
  input  logic [15:0] left_word_i,
  input  logic [15:0] right_word_i,
  input  logic [3:0]  offset_x_i,
  input  logic [4:0]  offset_y_i,
  input  logic [3:0]  offset_z_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [5:0]  typ;
  logic [5:0]  idx;
  logic [3:0]  low;
  logic [3:0]  step;
  logic [1:0]  grp;
  logic        sloped;
  logic [3:0]  raise;
  logic [15:0] words [NumFaces];

  assign typ      = slope_code_i[7:2];
  assign words[0] = lid_word_i;
  assign words[1] = bottom_word_i;
  assign words[2] = top_word_i;
  assign words[3] = left_word_i;
  assign words[4] = right_word_i;

  always_comb begin
    idx    = 6'd0;
    low    = 4'd0;
    step   = 4'd0;
    grp    = 2'd0;
    sloped = 1'b1;
    case (typ) inside
      [TYPE_TWO_LO:TYPE_TWO_HI]: begin
        idx  = typ - TYPE_TWO_LO;
        step = 4'd4;
        low  = idx[0] ? 4'b1100 : Z_FLOOR;
        grp  = idx[2:1];
      end
      [TYPE_EIGHT_LO:TYPE_EIGHT_HI]: begin
        idx  = typ - TYPE_EIGHT_LO;
        step = 4'd1;
        low  = {1'b0, idx[2:0]} - 4'd8;
        grp  = idx[4:3];
      end
      [TYPE_ONE_LO:TYPE_ONE_HI]: begin
        idx  = typ - TYPE_ONE_LO;
        step = 4'd8;
        low  = Z_FLOOR;
        grp  = idx[1:0];
      end
      default: begin
        sloped = 1'b0;
      end
    endcase

    case (grp)
      2'd0:    raise = 4'b1100;
      2'd1:    raise = 4'b0011;
      2'd2:    raise = 4'b1001;
      default: raise = 4'b0110;
    endcase

    for (int k = 0; k < 4; k++) begin
      entry_o.lid_z[k] = sloped ? (low + (raise[k] ? step : 4'd0)) : 4'd0;
    end

    for (int f = 0; f < NumFaces; f++) begin
      entry_o.face[f].tex  = words[f][TexW-1:0];
      entry_o.face[f].flip = words[f][FlipBit];
      entry_o.face[f].rot  = words[f][RotLsb +: 2];
      entry_o.mask[f]      = |words[f][TexW-1:0];
    end

    entry_o.ox = offset_x_i;
    entry_o.oy = offset_y_i;
    entry_o.oz = offset_z_i;
  end

  // untextured blocks are accepted and dropped here
  assign push_o = start_i & ~full_i & (|entry_o.mask);

endmodule

// File: rtl/sbfm_queue.sv
// ----------------------------------------------------------------------------
// sbfm_queue
// two-entry queue of classified blocks between front and back
// ----------------------------------------------------------------------------
module sbfm_queue import sbfm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/sbfm_back.sv
// ----------------------------------------------------------------------------
// sbfm_back
// walks the textured faces of the head block and emits one vertex a cycle while a block is at the head
// ----------------------------------------------------------------------------
module sbfm_back import sbfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  entry_t            head_i,
  output logic              pop_o,
  output logic              strobe_o,
  output logic [9:0]        texture_id_o,
  output logic [2:0]        face_kind_o,
  output logic [4:0]        pos_x_o,
  output logic signed [4:0] pos_y_o,
  output logic signed [7:0] pos_z_eighths_o,
  output logic signed [2:0] tex_u_o,
  output logic signed [2:0] tex_v_o,
  output logic              last_o
);

  logic [2:0]          vtx_q, vtx_d;
  logic [NumFaces-1:0] done_q, done_d;
  logic [NumFaces-1:0] pend;
  logic [NumFaces-1:0] pend_after;
  logic [2:0]          cur;
  face_t               fw;
  logic [1:0]          q;
  logic [2:0]          p;
  logic [3:0]          pz;
  logic                su, sv;
  logic signed [3:0]   hu, hv, ru, rv, tu, tv;
  logic                fin_face, fin_blk;

  logic                strobe_q;
  logic [9:0]          tex_q;
  logic [2:0]          face_q;
  logic [4:0]          px_q;
  logic [4:0]          py_q;
  logic [7:0]          pz_q;
  logic [2:0]          u_q, v_q;
  logic                last_q;

  assign pend       = head_i.mask & ~done_q;
  assign cur        = first_face(pend);
  assign pend_after = pend & ~(NumFaces'(1) << cur);
  assign fw         = head_i.face[cur];
  assign q          = tri_corner(vtx_q);
  assign p          = face_point(cur, q);
  assign pz         = p[2] ? Z_FLOOR : head_i.lid_z[p[1:0]];
  assign su         = sq_x(q);
  assign sv         = sq_y(q);
  assign fin_face   = valid_i && (vtx_q == VTX_LAST);
  assign fin_blk    = fin_face && (pend_after == '0);
  assign pop_o      = fin_blk;

  // texcoords in doubled units around the centre, mirrored then turned
  always_comb begin
    if (fw.flip) begin
      hu = su ? -4'sd3 : -4'sd1;
    end else begin
      hu = su ? 4'sd1 : -4'sd1;
    end
    hv = sv ? -4'sd3 : -4'sd1;
    case (rot_e'(fw.rot))
      ROT_0: begin
        ru = hu;
        rv = hv;
      end
      ROT_90: begin
        ru = hv;
        rv = -hu;
      end
      ROT_180: begin
        ru = -hu;
        rv = -hv;
      end
      default: begin
        ru = -hv;
        rv = hu;
      end
    endcase
    tu = (ru + 4'sd1) >>> 1;
    tv = (rv + 4'sd1) >>> 1;
  end

  always_comb begin
    vtx_d  = vtx_q;
    done_d = done_q;
    if (valid_i) begin
      if (fin_face) begin
        vtx_d  = 3'd0;
        done_d = fin_blk ? '0 : (done_q | (NumFaces'(1) << cur));
      end else begin
        vtx_d = vtx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q    <= 3'd0;
      done_q   <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      vtx_q    <= vtx_d;
      done_q   <= done_d;
      strobe_q <= valid_i;
      last_q   <= fin_blk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      tex_q  <= fw.tex;
      face_q <= cur;
      px_q   <= {1'b0, head_i.ox} + {4'd0, sq_x(p[1:0])};
      py_q   <= head_i.oy + {4'd0, sq_y(p[1:0])};
      pz_q   <= {{4{pz[3]}}, pz} + {1'b0, head_i.oz, 3'b000};
      u_q    <= tu[2:0];
      v_q    <= tv[2:0];
    end
  end

  assign strobe_o        = strobe_q;
  assign texture_id_o    = tex_q;
  assign face_kind_o     = face_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign pos_z_eighths_o = pz_q;
  assign tex_u_o         = u_q;
  assign tex_v_o         = v_q;
  assign last_o          = last_q;

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last without strobe");

  a_strobe_from_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(valid_i))
    else $error("vertex emitted with no block at the head");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> (vtx_q == 3'd0 && done_q == '0))
    else $error("walk state left over between blocks");

  a_done_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ((done_q & ~head_i.mask) == '0 && pend != '0))
    else $error("finished face outside the textured set");

endmodule

// File: rtl/sloped_block_face_mesher.sv
// ----------------------------------------------------------------------------
// sloped_block_face_mesher
// turns one map block into the triangle vertices of its textured faces
// ----------------------------------------------------------------------------
// a block is taken when start_i is high and busy_o is low; each face with a
// nonzero texture gives six vertices, one per cycle on strobe_o, in the order
// lid, bottom, top, left, right, with last_o on the final vertex of the block.
// blocks follow each other with no gap between their vertices while the next
// block already waits in the queue; a block with no textured face is accepted
// but never queued and gives no vertices at all. the emitter output is
// registered, so the first vertex appears the cycle after the block reaches
// the head of the two-entry queue. busy_o is high only while that queue is
// full. the receiver cannot stall:
// every strobe is a completed transfer.
// ----------------------------------------------------------------------------
module sloped_block_face_mesher import sbfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // block input
  input  logic              start_i,
  output logic              busy_o,
  input  logic [7:0]        slope_code_i,
  input  logic [15:0]       lid_word_i,
  input  logic [15:0]       bottom_word_i,
  input  logic [15:0]       top_word_i,
  input  logic [15:0]       left_word_i,
  input  logic [15:0]       right_word_i,
  input  logic [3:0]        offset_x_i,
  input  logic signed [4:0] offset_y_i,
  input  logic [3:0]        offset_z_i,
  // vertex output
  output logic              strobe_o,
  output logic [9:0]        texture_id_o,
  output logic [2:0]        face_kind_o,
  output logic [4:0]        pos_x_o,
  output logic signed [4:0] pos_y_o,
  output logic signed [7:0] pos_z_eighths_o,
  output logic signed [2:0] tex_u_o,
  output logic signed [2:0] tex_v_o,
  output logic              last_o
);

  logic   push;
  logic   pop;
  logic   full;
  logic   head_valid;
  entry_t entry;
  entry_t head;

  // busy only when the queue cannot take another block
  assign busy_o = full;

  // classification: lid heights in eighths and the textured face set
  sbfm_front u_front (
    .start_i       (start_i),
    .full_i        (full),
    .slope_code_i  (slope_code_i),
    .lid_word_i    (lid_word_i),
    .bottom_word_i (bottom_word_i),
    .top_word_i    (top_word_i),
    .left_word_i   (left_word_i),
    .right_word_i  (right_word_i),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .offset_z_i    (offset_z_i),
    .push_o        (push),
    .entry_o       (entry)
  );

  // decouples block intake from vertex emission
  sbfm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // vertex emitter, pops the head on its final vertex
  sbfm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .strobe_o        (strobe_o),
    .texture_id_o    (texture_id_o),
    .face_kind_o     (face_kind_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_eighths_o (pos_z_eighths_o),
    .tex_u_o         (tex_u_o),
    .tex_v_o         (tex_v_o),
    .last_o          (last_o)
  );

endmodule
